// ===== design/det_pkg.sv =====
// ----------------------------------------------------------------------------
// det_pkg
// shared types and constants of the directory entry table: operation kinds,
// status codes, controller states and the command/status bundles
// ----------------------------------------------------------------------------
`default_nettype none

package det_pkg;

   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;
   localparam int INODE_W  = 16;
   localparam int NAME_W   = 64;
   localparam int INDEX_W  = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 3'd0,
      KIND_APPEND = 3'd1,
      KIND_NEXT   = 3'd2,
      KIND_REWIND = 3'd3,
      KIND_LOOKUP = 3'd4,
      KIND_REMOVE = 3'd5,
      KIND_READ   = 3'd6
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_END      = 2'd2,
      STATUS_INACTIVE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH,
      ST_CAPTURE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_ZERO,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      ITER_HOLD,
      ITER_ZERO,
      ITER_INC
   } iter_op_type;

   typedef enum logic [2:0] {
      PTR_WALK,
      PTR_ZERO,
      PTR_ITER,
      PTR_IDX,
      PTR_IDX_NEXT
   } ptr_op_type;

   typedef enum logic [1:0] {
      RES_HOLD,
      RES_STATUS,
      RES_ENTRY
   } res_op_type;

   // controller to datapath
   typedef struct packed {
      logic        accept;
      cnt_op_type  cnt_op;
      iter_op_type iter_op;
      ptr_op_type  ptr_op;
      logic        walk;
      logic        append_wr;
      logic        shift_wr;
      res_op_type  res_op;
      status_type  res_status;
      logic        out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     iter_end;
      logic     idx_bad;
      logic     idx_inactive;
      logic     hit;
      logic     walk_done;
      logic     out_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== design/directory_entry_table.sv =====
// ----------------------------------------------------------------------------
// directory_entry_table
// packed table of directory entries (inode number and fixed-length name)
// with append, iterate, name lookup, compacting remove and indexed read
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    kind, inode_in, name_in, index_in
//   rsp_      out        rsp_valid/rsp_ready    status, index_out, inode_out,
//                                               name_out, valid_out
//
// one beat in gives one beat out; a new request is taken once the previous
// one has its result in the output register, even if that result still waits
// clear, append, rewind, next at end and rejected ops go decode, finish;
// next and read go decode, fetch, capture, finish; lookup and remove walk
// the entry memory one read per cycle in scan or shift: a lookup stops at
// the first hit or past the last entry, remove moves each entry above the
// index down by one slot through the single read port
// reset empties the table and the iterator at once, no clearing pass
// a stalled rsp_ready holds the finished result and keeps back the result, not the acceptance, of the next request
// ----------------------------------------------------------------------------
`default_nettype none

module directory_entry_table
   import det_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int NAME_BYTES    = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [INODE_W-1:0]  req_inode_in,
   input  wire logic [NAME_W-1:0]   req_name_in,
   input  wire logic [INDEX_W-1:0]  req_index_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [INDEX_W-1:0]       rsp_index_out,
   output logic [INODE_W-1:0]       rsp_inode_out,
   output logic [NAME_W-1:0]        rsp_name_out,
   output logic                     rsp_valid_out
);

   // commands from the sequencer, flags back from the datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: decodes the latched op, runs the lookup scan and the
   // compacting shift, and hands the result to the output register
   det_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_ready (req_ready)
   );

   // datapath: entry memory, count, iterator, walk pointer and result regs
   // live entries always sit in slots 0 .. count-1, so the count stands in
   // for the per-entry valid marks
   det_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NAME_BYTES    (NAME_BYTES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_kind      (req_kind),
      .req_inode_in  (req_inode_in),
      .req_name_in   (req_name_in),
      .req_index_in  (req_index_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_index_out (rsp_index_out),
      .rsp_inode_out (rsp_inode_out),
      .rsp_name_out  (rsp_name_out),
      .rsp_valid_out (rsp_valid_out)
   );

   // one request at a time: the cycle after an accept takes nothing new
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   // append never grows a full table
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (cmd.cnt_op == CNT_INC) |-> !stat.full)
      else $error("entry count grown past table size");

   // result only moves into a free output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");

   // the single write port is never claimed by append and shift together
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      cmd.append_wr |-> !cmd.shift_wr)
      else $error("append and shift write in the same cycle");

endmodule

`default_nettype wire

// ===== design/det_dpath.sv =====
// ----------------------------------------------------------------------------
// det_dpath
// entry memory, count and iterator registers, walk pointer, result and
// output registers of the directory entry table
// ----------------------------------------------------------------------------
`default_nettype none

module det_dpath
   import det_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int NAME_BYTES    = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output stat_type                 stat,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [INODE_W-1:0]  req_inode_in,
   input  wire logic [NAME_W-1:0]   req_name_in,
   input  wire logic [INDEX_W-1:0]  req_index_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [INDEX_W-1:0]       rsp_index_out,
   output logic [INODE_W-1:0]       rsp_inode_out,
   output logic [NAME_W-1:0]        rsp_name_out,
   output logic                     rsp_valid_out
);

   localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W   = $clog2(TABLE_ENTRIES);
   localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int STNAME_W = 8 * NAME_BYTES;
   localparam int ROW_W    = INODE_W + STNAME_W;

   // latched operation
   kind_type              op_kind_ff;
   logic [INODE_W-1:0]    op_inode_ff;
   logic [STNAME_W-1:0]   op_name_ff;
   logic [INDEX_W-1:0]    op_index_ff;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      iter_ff, iter_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      chk_ptr_ff;
   logic                  chk_valid_ff, chk_valid_in;

   logic [ROW_W-1:0]      mem [TABLE_ENTRIES];
   logic [ROW_W-1:0]      rd_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ROW_W-1:0]      wr_row;
   logic [CNT_W-1:0]      shift_dst;

   status_type            res_status_ff;
   logic [INDEX_W-1:0]    res_index_ff;
   logic [INODE_W-1:0]    res_inode_ff;
   logic [NAME_W-1:0]     res_name_ff;
   logic                  res_valid_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [INDEX_W-1:0]    rsp_index_ff;
   logic [INODE_W-1:0]    rsp_inode_ff;
   logic [NAME_W-1:0]     rsp_name_ff;
   logic                  rsp_valid_out_ff;

   logic [CMP_W-1:0]      idx_wide;
   logic                  issue;
   logic [INODE_W-1:0]    rd_inode;
   logic [STNAME_W-1:0]   rd_name;

   assign idx_wide = CMP_W'(op_index_ff);
   assign issue    = ptr_ff < count_ff;
   assign rd_inode = rd_ff[ROW_W-1 -: INODE_W];
   assign rd_name  = rd_ff[STNAME_W-1:0];

   always_comb begin
      stat.kind         = op_kind_ff;
      stat.full         = count_ff == CNT_W'(TABLE_ENTRIES);
      stat.iter_end     = iter_ff >= count_ff;
      stat.idx_bad      = idx_wide >= CMP_W'(TABLE_ENTRIES);
      stat.idx_inactive = idx_wide >= CMP_W'(count_ff);
      stat.hit          = chk_valid_ff && (rd_name == op_name_ff);
      stat.walk_done    = !issue && !chk_valid_ff;
      stat.out_free     = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_kind_ff  <= kind_type'(req_kind);
         op_inode_ff <= req_inode_in;
         op_name_ff  <= req_name_in[STNAME_W-1:0];
         op_index_ff <= req_index_in;
      end
   end

   // counters and walk pointer
   always_comb begin
      case (cmd.cnt_op)
         CNT_ZERO: count_in = '0;
         CNT_INC:  count_in = count_ff + CNT_W'(1);
         CNT_DEC:  count_in = count_ff - CNT_W'(1);
         default:  count_in = count_ff;
      endcase
      case (cmd.iter_op)
         ITER_ZERO: iter_in = '0;
         ITER_INC:  iter_in = iter_ff + CNT_W'(1);
         default:   iter_in = iter_ff;
      endcase
      case (cmd.ptr_op)
         PTR_ZERO:     ptr_in = '0;
         PTR_ITER:     ptr_in = iter_ff;
         PTR_IDX:      ptr_in = CNT_W'(idx_wide);
         PTR_IDX_NEXT: ptr_in = CNT_W'(idx_wide) + CNT_W'(1);
         default: begin
            if (cmd.walk && issue) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end else begin
               ptr_in = ptr_ff;
            end
         end
      endcase
      chk_valid_in = cmd.walk && issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         iter_ff      <= '0;
         ptr_ff       <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         iter_ff      <= iter_in;
         ptr_ff       <= ptr_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk) begin
         chk_ptr_ff <= ptr_ff;
      end
   end

   // entry memory: one write, one registered read per cycle
   assign shift_dst = chk_ptr_ff - CNT_W'(1);
   assign mem_we    = cmd.append_wr || (cmd.shift_wr && chk_valid_ff);
   assign wr_addr   = cmd.append_wr ? count_ff[ADDR_W-1:0] : shift_dst[ADDR_W-1:0];
   assign wr_row    = cmd.append_wr ? {op_inode_ff, op_name_ff} : rd_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_row;
      end
      rd_ff <= mem[ptr_ff[ADDR_W-1:0]];
   end

   // result staging
   always_ff @(posedge clock) begin
      case (cmd.res_op)
         RES_STATUS: begin
            res_status_ff <= cmd.res_status;
            res_index_ff  <= '0;
            res_inode_ff  <= '0;
            res_name_ff   <= '0;
            res_valid_ff  <= 1'b0;
         end
         RES_ENTRY: begin
            res_status_ff <= chk_valid_ff ? STATUS_OK : STATUS_INACTIVE;
            res_index_ff  <= INDEX_W'(chk_ptr_ff);
            res_inode_ff  <= rd_inode;
            res_name_ff   <= NAME_W'(rd_name);
            res_valid_ff  <= chk_valid_ff;
         end
         default: begin
         end
      endcase
   end

   // output register
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff    <= res_status_ff;
         rsp_index_ff     <= res_index_ff;
         rsp_inode_ff     <= res_inode_ff;
         rsp_name_ff      <= res_name_ff;
         rsp_valid_out_ff <= res_valid_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_index_out = rsp_index_ff;
   assign rsp_inode_out = rsp_inode_ff;
   assign rsp_name_out  = rsp_name_ff;
   assign rsp_valid_out = rsp_valid_out_ff;

endmodule

`default_nettype wire

// ===== design/det_ctrl.sv =====
// ----------------------------------------------------------------------------
// det_ctrl
// operation sequencer of the directory entry table
// ----------------------------------------------------------------------------
`default_nettype none

module det_ctrl
   import det_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire stat_type stat,
   output cmd_type       cmd,
   input  wire logic     req_valid,
   output logic          req_ready
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.accept     = 1'b0;
      cmd.cnt_op     = CNT_HOLD;
      cmd.iter_op    = ITER_HOLD;
      cmd.ptr_op     = PTR_WALK;
      cmd.walk       = 1'b0;
      cmd.append_wr  = 1'b0;
      cmd.shift_wr   = 1'b0;
      cmd.res_op     = RES_HOLD;
      cmd.res_status = STATUS_OK;
      cmd.out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in   = ST_FINISH;
            cmd.res_op = RES_STATUS;
            case (stat.kind)
               KIND_CLEAR: begin
                  cmd.cnt_op  = CNT_ZERO;
                  cmd.iter_op = ITER_ZERO;
               end
               KIND_APPEND: begin
                  if (stat.full) begin
                     cmd.res_status = STATUS_FULL;
                  end else begin
                     cmd.append_wr = 1'b1;
                     cmd.cnt_op    = CNT_INC;
                  end
               end
               KIND_NEXT: begin
                  if (stat.iter_end) begin
                     cmd.iter_op    = ITER_ZERO;
                     cmd.res_status = STATUS_END;
                  end else begin
                     cmd.iter_op = ITER_INC;
                     cmd.ptr_op  = PTR_ITER;
                     cmd.res_op  = RES_HOLD;
                     state_in    = ST_FETCH;
                  end
               end
               KIND_REWIND: begin
                  cmd.iter_op = ITER_ZERO;
               end
               KIND_LOOKUP: begin
                  cmd.iter_op = ITER_ZERO;
                  cmd.ptr_op  = PTR_ZERO;
                  cmd.res_op  = RES_HOLD;
                  state_in    = ST_SCAN;
               end
               KIND_REMOVE: begin
                  if (stat.idx_inactive) begin
                     cmd.res_status = STATUS_INACTIVE;
                  end else begin
                     cmd.ptr_op = PTR_IDX_NEXT;
                     cmd.res_op = RES_HOLD;
                     state_in   = ST_SHIFT;
                  end
               end
               KIND_READ: begin
                  if (stat.idx_bad) begin
                     cmd.res_status = STATUS_INACTIVE;
                  end else begin
                     cmd.ptr_op = PTR_IDX;
                     cmd.res_op = RES_HOLD;
                     state_in   = ST_FETCH;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_FETCH: begin
            cmd.walk = 1'b1;
            state_in = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            cmd.res_op = RES_ENTRY;
            state_in   = ST_FINISH;
         end
         ST_SCAN: begin
            cmd.walk = 1'b1;
            if (stat.hit) begin
               cmd.res_op = RES_ENTRY;
               state_in   = ST_FINISH;
            end else if (stat.walk_done) begin
               cmd.res_op     = RES_STATUS;
               cmd.res_status = STATUS_END;
               state_in       = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            cmd.walk     = 1'b1;
            cmd.shift_wr = 1'b1;
            if (stat.walk_done) begin
               cmd.cnt_op = CNT_DEC;
               cmd.res_op = RES_STATUS;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
